FILE: design/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg: shared types, constants and helpers of the segment classifier
// Request and result structs, kind codes and small geometry functions.
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int CoordBits = 16;
    localparam int FracBits  = 16;
    localparam int FixBits   = 32;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int CrossBits = ProdBits + 1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_SPAN  = 2'd2;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [DiffBits-1:0]  t_diff;
    typedef logic signed [FixBits-1:0]   t_fix;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by_coord;
        t_coord cx;
        t_coord cy;
        t_coord dx;
        t_coord dy;
    } t_in_req;

    typedef struct packed {
        logic [1:0] kind;
        t_fix       px;
        t_fix       py;
        t_fix       qx;
        t_fix       qy;
    } t_out_req;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    // Result fields known before the division; use_div adds the quotient to p
    typedef struct packed {
        logic [1:0] kind;
        logic       use_div;
        t_fix       px;
        t_fix       py;
        t_fix       qx;
        t_fix       qy;
    } t_side;

    function automatic logic lex_less(t_pt a, t_pt b);
        return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
    endfunction

    function automatic t_diff diff(t_coord from_v, t_coord to_v);
        return t_diff'(to_v) - t_diff'(from_v);
    endfunction

    function automatic t_fix to_fixed(t_coord v, int unsigned frac);
        t_fix e;
        e = t_fix'(v);
        return e << frac;
    endfunction

endpackage

FILE: design/sic_geom.sv
// ----------------------------------------------------------------------------
// sic_geom: geometry front end of the segment classifier
// Five stages: differences, products, cross and dot sums, classification,
// and the numerator product that feeds the divider.
// ----------------------------------------------------------------------------
module sic_geom import sic_pkg::*; #(
    parameter int FRAC_BITS = FracBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  t_in_req                       i_req,
    input  logic                          i_touch,
    output logic                          o_valid,
    output logic [CrossBits+DiffBits-1:0] o_prod_x,
    output logic [CrossBits+DiffBits-1:0] o_prod_y,
    output logic [CrossBits-1:0]          o_den,
    output logic                          o_neg_x,
    output logic                          o_neg_y,
    output t_side                         o_side
);

    localparam int PrBits = CrossBits + DiffBits;

    typedef logic signed [ProdBits-1:0]  t_prod;
    typedef logic signed [CrossBits-1:0] t_cross;

    // stage 1: differences and lexicographic ordering of each segment
    t_pt pa, pb, pc, pd;
    assign pa = {i_req.ax, i_req.ay};
    assign pb = {i_req.bx, i_req.by_coord};
    assign pc = {i_req.cx, i_req.cy};
    assign pd = {i_req.dx, i_req.dy};

    logic  r1_v;
    t_diff r1_ab_x, r1_ab_y, r1_ac_x, r1_ac_y, r1_ad_x, r1_ad_y, r1_cd_x, r1_cd_y;
    t_pt   r1_a, r1_mab, r1_xab, r1_mcd, r1_xcd;
    logic  n1_ba, n1_dc;

    assign n1_ba = lex_less(pb, pa);
    assign n1_dc = lex_less(pd, pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ab_x <= diff(pa.x, pb.x);
            r1_ab_y <= diff(pa.y, pb.y);
            r1_ac_x <= diff(pa.x, pc.x);
            r1_ac_y <= diff(pa.y, pc.y);
            r1_ad_x <= diff(pa.x, pd.x);
            r1_ad_y <= diff(pa.y, pd.y);
            r1_cd_x <= diff(pc.x, pd.x);
            r1_cd_y <= diff(pc.y, pd.y);
            r1_a    <= pa;
            r1_mab  <= n1_ba ? pb : pa;
            r1_xab  <= n1_ba ? pa : pb;
            r1_mcd  <= n1_dc ? pd : pc;
            r1_xcd  <= n1_dc ? pc : pd;
        end
    end

    // stage 2: all products, overlap ends
    logic  r2_v;
    t_prod r2_abx_cdy, r2_aby_cdx, r2_acx_aby, r2_acy_abx, r2_acx_cdy, r2_acy_cdx;
    t_prod r2_abx_abx, r2_aby_aby, r2_acx_abx, r2_acy_aby, r2_adx_abx, r2_ady_aby;
    t_pt   r2_a, r2_r1, r2_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_abx_cdy <= t_prod'(r1_ab_x) * t_prod'(r1_cd_y);
            r2_aby_cdx <= t_prod'(r1_ab_y) * t_prod'(r1_cd_x);
            r2_acx_aby <= t_prod'(r1_ac_x) * t_prod'(r1_ab_y);
            r2_acy_abx <= t_prod'(r1_ac_y) * t_prod'(r1_ab_x);
            r2_acx_cdy <= t_prod'(r1_ac_x) * t_prod'(r1_cd_y);
            r2_acy_cdx <= t_prod'(r1_ac_y) * t_prod'(r1_cd_x);
            r2_abx_abx <= t_prod'(r1_ab_x) * t_prod'(r1_ab_x);
            r2_aby_aby <= t_prod'(r1_ab_y) * t_prod'(r1_ab_y);
            r2_acx_abx <= t_prod'(r1_ac_x) * t_prod'(r1_ab_x);
            r2_acy_aby <= t_prod'(r1_ac_y) * t_prod'(r1_ab_y);
            r2_adx_abx <= t_prod'(r1_ad_x) * t_prod'(r1_ab_x);
            r2_ady_aby <= t_prod'(r1_ad_y) * t_prod'(r1_ab_y);
            r2_a       <= r1_a;
            r2_r1      <= lex_less(r1_mab, r1_mcd) ? r1_mcd : r1_mab;
            r2_r2      <= lex_less(r1_xcd, r1_xab) ? r1_xcd : r1_xab;
        end
    end

    // stage 3: cross and dot sums
    logic   r3_v, r3_eq;
    t_cross r3_c1, r3_c2, r3_tn, r3_n, r3_t0, r3_t1;
    t_pt    r3_a, r3_r1, r3_r2;
    t_diff  r3_ab_x, r3_ab_y;
    t_diff  r2_ab_x, r2_ab_y;

    // hold the AB difference one more stage for the magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ab_x <= r1_ab_x;
            r2_ab_y <= r1_ab_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c1   <= t_cross'(r2_abx_cdy) - t_cross'(r2_aby_cdx);
            r3_c2   <= t_cross'(r2_acx_aby) - t_cross'(r2_acy_abx);
            r3_tn   <= t_cross'(r2_acx_cdy) - t_cross'(r2_acy_cdx);
            r3_n    <= t_cross'(r2_abx_abx) + t_cross'(r2_aby_aby);
            r3_t0   <= t_cross'(r2_acx_abx) + t_cross'(r2_acy_aby);
            r3_t1   <= t_cross'(r2_adx_abx) + t_cross'(r2_ady_aby);
            r3_eq   <= (r2_r1 == r2_r2);
            r3_a    <= r2_a;
            r3_r1   <= r2_r1;
            r3_r2   <= r2_r2;
            r3_ab_x <= r2_ab_x;
            r3_ab_y <= r2_ab_y;
        end
    end

    // stage 4: classify
    t_cross n4_lo, n4_hi, n4_den, n4_tn, n4_un;
    logic   n4_coll, n4_ov, n4_ok;
    t_side  n4_side;

    always_comb begin
        n4_coll = (r3_c1 == '0) && (r3_c2 == '0);
        n4_lo   = (r3_t0 < r3_t1) ? r3_t0 : r3_t1;
        n4_hi   = (r3_t0 < r3_t1) ? r3_t1 : r3_t0;
        n4_ov   = i_touch ? ((n4_lo <= r3_n) && (n4_hi >= 0))
                          : ((n4_lo <  r3_n) && (n4_hi >  0));
        n4_den  = (r3_c1 < 0) ? -r3_c1 : r3_c1;
        n4_tn   = (r3_c1 < 0) ? -r3_tn : r3_tn;
        n4_un   = (r3_c1 < 0) ? -r3_c2 : r3_c2;
        n4_ok   = i_touch ? ((n4_tn >= 0) && (n4_tn <= n4_den) &&
                             (n4_un >= 0) && (n4_un <= n4_den))
                          : ((n4_tn >  0) && (n4_tn <  n4_den) &&
                             (n4_un >  0) && (n4_un <  n4_den));
        n4_side = '0;
        if (n4_coll) begin
            if ((r3_n != '0) && n4_ov) begin
                n4_side.px = to_fixed(r3_r1.x, FRAC_BITS);
                n4_side.py = to_fixed(r3_r1.y, FRAC_BITS);
                if (r3_eq) begin
                    n4_side.kind = KIND_POINT;
                end else begin
                    n4_side.kind = KIND_SPAN;
                    n4_side.qx   = to_fixed(r3_r2.x, FRAC_BITS);
                    n4_side.qy   = to_fixed(r3_r2.y, FRAC_BITS);
                end
            end
        end else if ((r3_c1 != '0) && n4_ok) begin
            n4_side.kind    = KIND_POINT;
            n4_side.use_div = 1'b1;
            n4_side.px      = to_fixed(r3_a.x, FRAC_BITS);
            n4_side.py      = to_fixed(r3_a.y, FRAC_BITS);
        end
    end

    logic                 r4_v, r4_neg_x, r4_neg_y;
    t_side                r4_side;
    logic [CrossBits-1:0] r4_den, r4_tn;
    logic [DiffBits-1:0]  r4_mag_x, r4_mag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side  <= n4_side;
            r4_den   <= n4_den;
            r4_tn    <= n4_tn;
            r4_neg_x <= r3_ab_x < 0;
            r4_neg_y <= r3_ab_y < 0;
            r4_mag_x <= (r3_ab_x < 0) ? -r3_ab_x : r3_ab_x;
            r4_mag_y <= (r3_ab_y < 0) ? -r3_ab_y : r3_ab_y;
        end
    end

    // stage 5: numerator products
    logic r5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod_x <= PrBits'(r4_tn) * PrBits'(r4_mag_x);
            o_prod_y <= PrBits'(r4_tn) * PrBits'(r4_mag_y);
            o_den    <= r4_den;
            o_neg_x  <= r4_neg_x;
            o_neg_y  <= r4_neg_y;
            o_side   <= r4_side;
        end
    end

    assign o_valid = r5_v;

endmodule

FILE: design/sic_div.sv
// ----------------------------------------------------------------------------
// sic_div: pipelined restoring divider, both axes
// One quotient bit per stage for the scaled x and y numerators over one
// shared denominator; sideband fields travel alongside.
// ----------------------------------------------------------------------------
module sic_div import sic_pkg::*; #(
    parameter int FRAC_BITS = FracBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [CrossBits+DiffBits-1:0] i_prod_x,
    input  logic [CrossBits+DiffBits-1:0] i_prod_y,
    input  logic [CrossBits-1:0]          i_den,
    input  logic                          i_neg_x,
    input  logic                          i_neg_y,
    input  t_side                         i_side,
    output logic                          o_valid,
    output logic [DiffBits+FRAC_BITS-1:0] o_q_x,
    output logic [DiffBits+FRAC_BITS-1:0] o_q_y,
    output logic                          o_rnz_x,
    output logic                          o_rnz_y,
    output logic                          o_neg_x,
    output logic                          o_neg_y,
    output t_side                         o_side
);

    localparam int PrBits = CrossBits + DiffBits;
    localparam int NumW   = PrBits + FRAC_BITS;
    localparam int QB     = DiffBits + FRAC_BITS;
    localparam int RemW   = CrossBits;

    logic [NumW-1:0] num_x, num_y;
    assign num_x = NumW'(i_prod_x) << FRAC_BITS;
    assign num_y = NumW'(i_prod_y) << FRAC_BITS;

    logic            r_v     [QB];
    logic [RemW-1:0] r_rem_x [QB];
    logic [RemW-1:0] r_rem_y [QB];
    logic [QB-1:0]   r_low_x [QB];
    logic [QB-1:0]   r_low_y [QB];
    logic [QB-1:0]   r_q_x   [QB];
    logic [QB-1:0]   r_q_y   [QB];
    logic [RemW-1:0] r_den   [QB];
    logic            r_neg_x [QB];
    logic            r_neg_y [QB];
    t_side           r_side  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_bit
        logic            p_v, p_neg_x, p_neg_y;
        logic [RemW-1:0] p_rem_x, p_rem_y, p_den;
        logic [QB-1:0]   p_low_x, p_low_y, p_q_x, p_q_y;
        t_side           p_side;
        logic [RemW:0]   n_try_x, n_try_y;
        logic            n_ge_x, n_ge_y;

        if (k == 0) begin : g_first
            assign p_v     = i_valid;
            assign p_rem_x = num_x[NumW-1:QB];
            assign p_rem_y = num_y[NumW-1:QB];
            assign p_low_x = num_x[QB-1:0];
            assign p_low_y = num_y[QB-1:0];
            assign p_q_x   = '0;
            assign p_q_y   = '0;
            assign p_den   = i_den;
            assign p_neg_x = i_neg_x;
            assign p_neg_y = i_neg_y;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_v     = r_v[k-1];
            assign p_rem_x = r_rem_x[k-1];
            assign p_rem_y = r_rem_y[k-1];
            assign p_low_x = r_low_x[k-1];
            assign p_low_y = r_low_y[k-1];
            assign p_q_x   = r_q_x[k-1];
            assign p_q_y   = r_q_y[k-1];
            assign p_den   = r_den[k-1];
            assign p_neg_x = r_neg_x[k-1];
            assign p_neg_y = r_neg_y[k-1];
            assign p_side  = r_side[k-1];
        end

        always_comb begin
            n_try_x = {p_rem_x, p_low_x[QB-1]};
            n_try_y = {p_rem_y, p_low_y[QB-1]};
            n_ge_x  = n_try_x >= {1'b0, p_den};
            n_ge_y  = n_try_y >= {1'b0, p_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[k] <= n_ge_x ? RemW'(n_try_x - {1'b0, p_den}) : n_try_x[RemW-1:0];
                r_rem_y[k] <= n_ge_y ? RemW'(n_try_y - {1'b0, p_den}) : n_try_y[RemW-1:0];
                r_low_x[k] <= {p_low_x[QB-2:0], 1'b0};
                r_low_y[k] <= {p_low_y[QB-2:0], 1'b0};
                r_q_x[k]   <= {p_q_x[QB-2:0], n_ge_x};
                r_q_y[k]   <= {p_q_y[QB-2:0], n_ge_y};
                r_den[k]   <= p_den;
                r_neg_x[k] <= p_neg_x;
                r_neg_y[k] <= p_neg_y;
                r_side[k]  <= p_side;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_q_x   = r_q_x[QB-1];
    assign o_q_y   = r_q_y[QB-1];
    assign o_rnz_x = |r_rem_x[QB-1];
    assign o_rnz_y = |r_rem_y[QB-1];
    assign o_neg_x = r_neg_x[QB-1];
    assign o_neg_y = r_neg_y[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

FILE: design/sic_out.sv
// ----------------------------------------------------------------------------
// sic_out: result assembly, output register and skid stage
// Apply floor rounding to the quotient, add it to the start point, and
// hold results against downstream stall.
// ----------------------------------------------------------------------------
module sic_out import sic_pkg::*; #(
    parameter int FRAC_BITS = FracBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [DiffBits+FRAC_BITS-1:0] i_q_x,
    input  logic [DiffBits+FRAC_BITS-1:0] i_q_y,
    input  logic                          i_rnz_x,
    input  logic                          i_rnz_y,
    input  logic                          i_neg_x,
    input  logic                          i_neg_y,
    input  t_side                         i_side,
    input  logic                          i_stall,
    output logic                          o_en,
    output logic                          o_valid,
    output t_out_req                      o_res
);

    localparam int QB = DiffBits + FRAC_BITS;
    localparam int XW = (QB + 1 > FixBits) ? QB + 1 : FixBits;

    logic [XW-1:0] n_ext_x, n_ext_y, n_val_x, n_val_y;
    t_out_req      n_res;

    always_comb begin
        n_ext_x    = XW'(i_q_x);
        n_ext_y    = XW'(i_q_y);
        // floor toward minus infinity: bump the magnitude on a remainder
        n_val_x    = i_neg_x ? -(n_ext_x + XW'(i_rnz_x)) : n_ext_x;
        n_val_y    = i_neg_y ? -(n_ext_y + XW'(i_rnz_y)) : n_ext_y;
        n_res.kind = i_side.kind;
        n_res.px   = i_side.use_div ? i_side.px + n_val_x[FixBits-1:0] : i_side.px;
        n_res.py   = i_side.use_div ? i_side.py + n_val_y[FixBits-1:0] : i_side.py;
        n_res.qx   = i_side.qx;
        n_res.qy   = i_side.qy;
    end

    logic     r_out_v, r_skid_v;
    t_out_req r_out, r_skid;
    logic     take;

    assign o_en = !r_skid_v;
    assign take = i_valid && o_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            r_out_v  <= r_skid_v || take;
            r_skid_v <= 1'b0;
        end else if (take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (take) begin
            r_skid <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a request while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_stall |=> !r_skid_v && r_out_v)
        else $error("skid did not drain into the output register");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_out.kind == KIND_NONE) |->
            (r_out.px == '0) && (r_out.py == '0) && (r_out.qx == '0) && (r_out.qy == '0))
        else $error("disjoint result carries nonzero points");

    a_point_q_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_out.kind == KIND_POINT) |-> (r_out.qx == '0) && (r_out.qy == '0))
        else $error("single point result carries a nonzero end point");
`endif

endmodule

FILE: design/segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// segment_intersection_classifier: two-segment intersection classifier
// Classify segments AB and CD as disjoint, single point or collinear overlap,
// with exact integer tests and a floor-rounded fixed-point crossing point.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  request   in         i_valid / o_stall         i_req  (t_in_req)
//  result    out        o_valid / i_stall         o_res  (t_out_req)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (touch_counts)
//
//  Throughput is one request per cycle while o_stall is low. A request passes
//  the geometry stages, the one-bit-per-stage divider and the output register.
//  Reset is synchronous, active low; it clears all valid bits and sets
//  touch_counts to 1. A stalled result parks in a skid register; while the
//  skid is full the whole pipeline holds and o_stall is high.
//
module segment_intersection_classifier import sic_pkg::*; #(
    parameter int FRAC_BITS = FracBits
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    // result channel
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_res,
    // configuration channel
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    localparam int PrBits = CrossBits + DiffBits;
    localparam int QB     = DiffBits + FRAC_BITS;

    // touch_counts: inclusive bounds when set
    logic r_touch;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_touch <= i_cfg_data;
        end
    end

    // one enable for every geometry and divider stage; drop it only while the skid is full
    logic en;
    assign o_stall = !en;

    logic              g_valid, g_neg_x, g_neg_y;
    logic [PrBits-1:0] g_prod_x, g_prod_y;
    logic [CrossBits-1:0] g_den;
    t_side             g_side;

    sic_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_req    (i_req),
        .i_touch  (r_touch),
        .o_valid  (g_valid),
        .o_prod_x (g_prod_x),
        .o_prod_y (g_prod_y),
        .o_den    (g_den),
        .o_neg_x  (g_neg_x),
        .o_neg_y  (g_neg_y),
        .o_side   (g_side)
    );

    logic          d_valid, d_rnz_x, d_rnz_y, d_neg_x, d_neg_y;
    logic [QB-1:0] d_q_x, d_q_y;
    t_side         d_side;

    sic_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (g_valid),
        .i_prod_x (g_prod_x),
        .i_prod_y (g_prod_y),
        .i_den    (g_den),
        .i_neg_x  (g_neg_x),
        .i_neg_y  (g_neg_y),
        .i_side   (g_side),
        .o_valid  (d_valid),
        .o_q_x    (d_q_x),
        .o_q_y    (d_q_y),
        .o_rnz_x  (d_rnz_x),
        .o_rnz_y  (d_rnz_y),
        .o_neg_x  (d_neg_x),
        .o_neg_y  (d_neg_y),
        .o_side   (d_side)
    );

    // round, add the start point, hold against stall
    sic_out #(.FRAC_BITS(FRAC_BITS)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_q_x   (d_q_x),
        .i_q_y   (d_q_y),
        .i_rnz_x (d_rnz_x),
        .i_rnz_y (d_rnz_y),
        .i_neg_x (d_neg_x),
        .i_neg_y (d_neg_y),
        .i_side  (d_side),
        .i_stall (i_stall),
        .o_en    (en),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
